### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the frame scaler.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while the reset is asserted.
`define NNFS_ASSERT_CLKD(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) prop) else $error(msg);

// Clocked check that also holds while the reset is asserted.
`define NNFS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

### src/nnfs_pkg.sv
// ----------------------------------------------------------------------------
// nnfs_pkg
// Field widths, register codes and request records of the frame scaler.
// ----------------------------------------------------------------------------
package nnfs_pkg;

	// Configuration register port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_WIDTH  = 2'd0,
		CFG_SRC_HEIGHT = 2'd1,
		CFG_DSP_WIDTH  = 2'd2,
		CFG_DSP_HEIGHT = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	// Register and field widths.
	localparam int SRC_W_W = 10;
	localparam int SRC_H_W = 9;
	localparam int DSP_W   = 11;
	localparam int WIDX_W  = 17;
	localparam int PIX_W   = 32;

	localparam logic [SRC_W_W-1:0] SRC_W_RESET = 10'd320;
	localparam logic [SRC_H_W-1:0] SRC_H_RESET = 9'd200;
	localparam logic [DSP_W-1:0]   DSP_W_RESET = 11'd1280;
	localparam logic [DSP_W-1:0]   DSP_H_RESET = 11'd720;

	// Scaling datapath widths.
	localparam int ROW_PROD_W  = DSP_W + SRC_H_W;
	localparam int COL_PROD_W  = DSP_W + SRC_W_W;
	localparam int QUO_W       = SRC_W_W;
	localparam int DIV_STAGES  = QUO_W;
	localparam int ROW_W       = SRC_H_W;
	localparam int COL_W       = SRC_W_W;
	localparam int ADDR_PROD_W = ROW_W + SRC_W_W;
	// Wide enough for the sampled address, the write index and the largest store depth.
	localparam int LIN_W       = 21;

	// Result queue; must cover the pipeline latency plus the output turnaround.
	localparam int RES_DEPTH = 16;
	localparam int RES_AW    = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	typedef struct packed {
		logic              valid;
		op_t               op;
		logic [WIDX_W-1:0] widx;
		logic [PIX_W-1:0]  pixel;
		logic              oor;
	} req_t;

	typedef struct packed {
		logic             valid;
		logic [PIX_W-1:0] pixel;
		logic             oor;
	} res_t;

endpackage

### src/nnfs_div.sv
// ----------------------------------------------------------------------------
// nnfs_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module nnfs_div #(
	parameter int DVD_W = 21,
	parameter int DEN_W = 11,
	parameter int QUO_W = 10
) (
	input  logic             clk,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [QUO_W-1:0] quotient
);

	localparam int CW = (DVD_W > DEN_W + QUO_W) ? DVD_W : DEN_W + QUO_W;

	logic [CW-1:0]    rem_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];
	logic [CW-1:0]    rem_nx [QUO_W];
	logic [QUO_W-1:0] quo_nx [QUO_W];

	// The caller guarantees that the quotient fits in QUO_W bits, so the
	// first trial subtraction may start at divisor << (QUO_W-1).
	always_comb begin
		logic [CW-1:0]    rin;
		logic [QUO_W-1:0] qin;
		logic [CW-1:0]    trial;
		logic             ge;
		for (int k = 0; k < QUO_W; k++) begin
			if (k == 0) begin
				rin = CW'(dividend);
				qin = '0;
			end else begin
				rin = rem_s[k-1];
				qin = quo_s[k-1];
			end
			trial = CW'(divisor) << (QUO_W - 1 - k);
			ge = (rin >= trial);
			rem_nx[k] = ge ? (rin - trial) : rin;
			quo_nx[k] = {qin[QUO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		rem_s <= rem_nx;
		quo_s <= quo_nx;
	end

	assign quotient = quo_s[QUO_W-1];

endmodule

### src/nnfs_frame_store.sv
// ----------------------------------------------------------------------------
// nnfs_frame_store
// Source frame memory with the address stage and the registered read.
// ----------------------------------------------------------------------------
module nnfs_frame_store #(
	parameter int SOURCE_DEPTH = 131072,
	parameter int PIXEL_BITS   = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  nnfs_pkg::req_t                 req,
	input  logic [nnfs_pkg::ROW_W-1:0]     row,
	input  logic [nnfs_pkg::COL_W-1:0]     col,
	input  logic [nnfs_pkg::SRC_W_W-1:0]   src_width,
	output nnfs_pkg::res_t                 res
);

	import nnfs_pkg::*;

	localparam int AW = $clog2(SOURCE_DEPTH);

	logic [PIXEL_BITS-1:0] frame_mem_q [SOURCE_DEPTH];

	req_t                   req_s12;
	logic [ADDR_PROD_W-1:0] prod_s12;
	logic [COL_W-1:0]       col_s12;

	logic [LIN_W-1:0] rd_lin;
	logic [LIN_W-1:0] wr_lin;
	logic             rd_ok;
	logic             do_write;

	logic [PIXEL_BITS-1:0] rdata_s13;
	logic                  rvalid_s13;
	logic                  oor_s13;
	logic                  hit_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s12 <= '0;
		end else begin
			req_s12 <= req;
		end
	end

	always_ff @(posedge clk) begin
		prod_s12 <= ADDR_PROD_W'(row) * ADDR_PROD_W'(src_width);
		col_s12  <= col;
	end

	assign rd_lin   = LIN_W'(prod_s12) + LIN_W'(col_s12);
	assign rd_ok    = (rd_lin < LIN_W'(SOURCE_DEPTH));
	assign wr_lin   = LIN_W'(req_s12.widx);
	assign do_write = req_s12.valid && (req_s12.op == OP_WRITE)
		&& (wr_lin < LIN_W'(SOURCE_DEPTH));

	// One port serves writes and reads in request order, so a read always
	// sees exactly the writes accepted before it and no overlap can occur.
	always_ff @(posedge clk) begin
		if (do_write) begin
			frame_mem_q[wr_lin[AW-1:0]] <= req_s12.pixel[PIXEL_BITS-1:0];
		end else begin
			rdata_s13 <= frame_mem_q[rd_lin[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_s13 <= 1'b0;
		end else begin
			rvalid_s13 <= req_s12.valid && (req_s12.op == OP_READ);
		end
	end

	always_ff @(posedge clk) begin
		oor_s13 <= req_s12.oor;
		hit_s13 <= rd_ok;
	end

	always_comb begin
		res.valid = rvalid_s13;
		res.oor   = oor_s13;
		res.pixel = (hit_s13 && !oor_s13) ? PIX_W'(rdata_s13) : '0;
	end

endmodule

### src/nnfs_res_fifo.sv
// ----------------------------------------------------------------------------
// nnfs_res_fifo
// Result queue between the sampling pipeline and the output channel.
// ----------------------------------------------------------------------------
module nnfs_res_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nnfs_pkg::res_t             push,
	input  logic                       pop,
	output logic                       not_empty,
	output logic [nnfs_pkg::PIX_W-1:0] head_pixel,
	output logic                       head_oor
);

	import nnfs_pkg::*;

	logic [PIX_W:0]       entry_q [RES_DEPTH];
	logic [RES_AW-1:0]    wr_ptr_q;
	logic [RES_AW-1:0]    rd_ptr_q;
	logic [RES_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= {push.oor, push.pixel};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			priority if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign not_empty  = (count_q != '0);
	assign head_pixel = entry_q[rd_ptr_q][PIX_W-1:0];
	assign head_oor   = entry_q[rd_ptr_q][PIX_W];

endmodule

### src/nearest_neighbour_frame_scaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbour_frame_scaler
// Source frame store with nearest-neighbour sampling of display pixels.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_stall) carries write and read requests. A
// write (op 0) stores pixel_in at write_index and returns nothing; a read
// (op 1) maps display_x/display_y onto the source frame and returns one
// result on the output channel (out_valid/out_stall).
// Throughput is one request per cycle of either kind while in_stall is low. A
// read's result passes through a chain of registers once the request is
// accepted: the scale products are registered at the accepting edge, then
// the stages of the two dividers (one quotient bit per stage), the address
// product, the memory read and the write into the result queue. The single
// memory port takes one write or one read per cycle.
// Up to 16 reads may be outstanding, bounded by the result queue; in_stall
// rises when 16 accepted reads have not yet been taken and falls as results
// are taken, so a stalled receiver holds results in the queue while new
// requests keep flowing until it fills. Writes need no queue space.
// Reset clears the pipeline and the queue and holds in_stall high; the
// frame memory itself is not cleared and must be written before it is read.
// Configuration registers may only be written while no request is in flight.
// ----------------------------------------------------------------------------
module nearest_neighbour_frame_scaler #(
	parameter int SOURCE_DEPTH = 131072,
	parameter int PIXEL_BITS   = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [nnfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nnfs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            op,
	input  logic [nnfs_pkg::WIDX_W-1:0]     write_index,
	input  logic [nnfs_pkg::PIX_W-1:0]      pixel_in,
	input  logic [nnfs_pkg::DSP_W-1:0]      display_x,
	input  logic [nnfs_pkg::DSP_W-1:0]      display_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [nnfs_pkg::PIX_W-1:0]      pixel_out,
	output logic                            out_of_range
);

	import nnfs_pkg::*;

	logic [SRC_W_W-1:0] src_w_q;
	logic [SRC_H_W-1:0] src_h_q;
	logic [DSP_W-1:0]   dsp_w_q;
	logic [DSP_W-1:0]   dsp_h_q;

	logic                 in_take;
	logic                 out_take;
	logic                 read_take;
	logic [RES_CNT_W-1:0] credit_q;

	req_t                  req_s1;
	logic [ROW_PROD_W-1:0] row_prod_s1;
	logic [COL_PROD_W-1:0] col_prod_s1;
	req_t                  req_dly_q [DIV_STAGES];

	logic [QUO_W-1:0] row_quo;
	logic [QUO_W-1:0] col_quo;
	res_t             res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SRC_W_RESET;
			src_h_q <= SRC_H_RESET;
			dsp_w_q <= DSP_W_RESET;
			dsp_h_q <= DSP_H_RESET;
		end else if (cfg_write) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SRC_WIDTH:  src_w_q <= cfg_data[SRC_W_W-1:0];
				CFG_SRC_HEIGHT: src_h_q <= cfg_data[SRC_H_W-1:0];
				CFG_DSP_WIDTH:  dsp_w_q <= cfg_data[DSP_W-1:0];
				CFG_DSP_HEIGHT: dsp_h_q <= cfg_data[DSP_W-1:0];
			endcase
		end
	end

	// Credits count reads accepted but not yet taken at the output.
	assign in_stall  = !arst_n || (credit_q == RES_CNT_W'(RES_DEPTH));
	assign in_take   = in_valid && !in_stall;
	assign read_take = in_take && (op == OP_READ);
	assign out_take  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			priority if (read_take && !out_take) begin
				credit_q <= credit_q + 1'b1;
			end else if (out_take && !read_take) begin
				credit_q <= credit_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else begin
			req_s1.valid <= in_take;
			req_s1.op    <= op_t'(op);
			req_s1.widx  <= write_index;
			req_s1.pixel <= pixel_in;
			// A zero display size makes every coordinate fall outside.
			req_s1.oor   <= (display_x >= dsp_w_q) || (display_y >= dsp_h_q);
		end
	end

	always_ff @(posedge clk) begin
		row_prod_s1 <= ROW_PROD_W'(display_y) * ROW_PROD_W'(src_h_q);
		col_prod_s1 <= COL_PROD_W'(display_x) * COL_PROD_W'(src_w_q);
	end

	// The request record travels beside the dividers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_dly_q <= '{default: '0};
		end else begin
			req_dly_q[0] <= req_s1;
			for (int i = 1; i < DIV_STAGES; i++) begin
				req_dly_q[i] <= req_dly_q[i-1];
			end
		end
	end

	nnfs_div #(
		.DVD_W (ROW_PROD_W),
		.DEN_W (DSP_W),
		.QUO_W (QUO_W)
	) u_row_div (
		.clk      (clk),
		.dividend (row_prod_s1),
		.divisor  (dsp_h_q),
		.quotient (row_quo)
	);

	nnfs_div #(
		.DVD_W (COL_PROD_W),
		.DEN_W (DSP_W),
		.QUO_W (QUO_W)
	) u_col_div (
		.clk      (clk),
		.dividend (col_prod_s1),
		.divisor  (dsp_w_q),
		.quotient (col_quo)
	);

	nnfs_frame_store #(
		.SOURCE_DEPTH (SOURCE_DEPTH),
		.PIXEL_BITS   (PIXEL_BITS)
	) u_frame_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_dly_q[DIV_STAGES-1]),
		.row       (row_quo[ROW_W-1:0]),
		.col       (col_quo[COL_W-1:0]),
		.src_width (src_w_q),
		.res       (res)
	);

	nnfs_res_fifo u_res_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res),
		.pop        (out_take),
		.not_empty  (out_valid),
		.head_pixel (pixel_out),
		.head_oor   (out_of_range)
	);

endmodule

### src/nnfs_checker.sv
// ----------------------------------------------------------------------------
// nnfs_checker
// Port-level checks of the frame scaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nnfs_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       op,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [nnfs_pkg::PIX_W-1:0] pixel_out,
	input  logic                       out_of_range
);

	import nnfs_pkg::*;

	logic [7:0] pending_q;
	logic       rd_req;
	logic       rd_res;

	assign rd_req = in_valid && !in_stall && (op == OP_READ);
	assign rd_res = out_valid && !out_stall;

	// Reads accepted at the input and not yet delivered at the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {7'd0, rd_req} - {7'd0, rd_res};
		end
	end

	`NNFS_ASSERT_CLKD(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(out_of_range), "stalled result changed")
	`NNFS_ASSERT_CLKD(a_oor_zero, clk, arst_n, out_valid && out_of_range |-> pixel_out == '0, "out of range result carries a pixel")
	`NNFS_ASSERT_CLKD(a_no_phantom, clk, arst_n, out_valid |-> pending_q != 8'd0, "result without a pending read")
	`NNFS_ASSERT_CLKD(a_stall_cause, clk, arst_n, in_stall |-> pending_q != 8'd0, "input stalled with no read pending")
	`NNFS_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> in_stall && !out_valid, "channels active during reset")

endmodule

bind nearest_neighbour_frame_scaler nnfs_checker u_nnfs_checker (.*);
